// ===== design/fpa_pkg.sv =====
// shared types and operation codes for the fixed-point alu
package fpa_pkg;

    typedef enum logic [3:0] {
        FN_ADD  = 4'd0,
        FN_SUB  = 4'd1,
        FN_MUL  = 4'd2,
        FN_DIV  = 4'd3,
        FN_LT   = 4'd4,
        FN_GT   = 4'd5,
        FN_LE   = 4'd6,
        FN_GE   = 4'd7,
        FN_EQ   = 4'd8,
        FN_NE   = 4'd9,
        FN_INC  = 4'd10,
        FN_DEC  = 4'd11,
        FN_MIN  = 4'd12,
        FN_MAX  = 4'd13,
        FN_FINT = 4'd14,
        FN_TINT = 4'd15
    } func_t;

    localparam int DATA_W = 32;

    // per-item control that rides along the divider pipeline
    typedef struct packed {
        func_t             func;
        logic [DATA_W-1:0] simple;
        logic              flag;
        logic              dz;
        logic              neg;
    } tag_t;

endpackage

// ===== design/fpa_mul.sv =====
// pipelined signed multiply with arithmetic shift by the fraction width
module fpa_mul #(
    parameter int FRAC_W = 8,
    parameter int LAT = 4
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic signed [31:0]        a,
    input  logic signed [31:0]        b,
    output logic [31:0]               p
);
    import fpa_pkg::*;

    // 32x32 in one stage, then registers to match the divider depth
    logic signed [63:0] prod_reg [LAT];

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg[0] <= a * b;
            for (int i = 1; i < LAT; i++) prod_reg[i] <= prod_reg[i-1];
        end
    end

    logic signed [63:0] shifted;
    assign shifted = prod_reg[LAT-1] >>> FRAC_W;
    assign p = shifted[DATA_W-1:0];
endmodule

// ===== design/fpa_div.sv =====
// pipelined restoring divider, one quotient bit per stage slice
module fpa_div #(
    parameter int FRAC_W = 8,
    parameter int STAGES = 6
) (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] num_mag,
    input  logic [31:0] den_mag,
    output logic [31:0] q
);
    import fpa_pkg::*;

    localparam int NW = DATA_W + FRAC_W;
    localparam int BPS = (NW + STAGES - 1) / STAGES;
    localparam int TOT = BPS * STAGES;

    // numerator shifts left into the remainder; quotient fills the low bits
    logic [TOT-1:0]    n_reg [STAGES];
    logic [DATA_W:0]   r_reg [STAGES];
    logic [DATA_W-1:0] d_reg [STAGES];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < STAGES; s++) begin
                logic [TOT-1:0]  n;
                logic [DATA_W:0] r;
                logic [DATA_W:0] t;
                logic [DATA_W-1:0] d;
                if (s == 0) begin
                    n = TOT'({num_mag, {FRAC_W{1'b0}}});
                    r = '0;
                    d = den_mag;
                end else begin
                    n = n_reg[s-1];
                    r = r_reg[s-1];
                    d = d_reg[s-1];
                end
                for (int k = 0; k < BPS; k++) begin
                    r = {r[DATA_W-1:0], n[TOT-1]};
                    n = {n[TOT-2:0], 1'b0};
                    t = r - {1'b0, d};
                    if (!t[DATA_W]) begin
                        r = t;
                        n[0] = 1'b1;
                    end
                end
                n_reg[s] <= n;
                r_reg[s] <= r;
                d_reg[s] <= d;
            end
        end
    end

    assign q = n_reg[STAGES-1][DATA_W-1:0];
endmodule

// ===== design/fixed_point_alu.sv =====
// top level of the pipelined fixed-point alu
//  channel | dir | tdata (low bit up)                | tuser
//  s_      | in  | operand_a[31:0], operand_b[63:32] | func[3:0]
//  m_      | out | result_value[31:0]                | compare_flag[0], divide_by_zero[1]
// one item per cycle while the output is not stalled; one input stage, six divider stages
// (seven quotient bits each at the default fraction width), one output register;
// multiply aligns to the same depth.
// aresetn clears valid bits only. a stall freezes every stage together; the
// pipeline advances when the output register is empty or being taken.
module fixed_point_alu #(
    parameter int FRAC_W = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // operand_a, operand_b
    input  logic [3:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // result_value
    output logic [1:0]  m_tuser    // compare_flag, divide_by_zero
);
    import fpa_pkg::*;

    localparam int DSTG = 6;
    localparam int DEPTH = DSTG + 1;

    logic adv;
    logic [DEPTH-1:0] vld_reg;
    tag_t tag_reg [DEPTH];
    logic        out_v_reg;
    logic [31:0] out_d_reg;
    logic [1:0]  out_u_reg;

    assign adv = !out_v_reg || m_tready;
    assign s_tready = adv;

    func_t func_in;
    logic signed [31:0] a, b;
    assign func_in = func_t'(s_tuser);
    assign a = s_tdata[31:0];
    assign b = s_tdata[63:32];

    tag_t tag_in;
    logic [31:0] amag, bmag;
    always_comb begin
        tag_in = '0;
        tag_in.func = func_in;
        amag = a[31] ? 32'(-a) : a;
        bmag = b[31] ? 32'(-b) : b;
        tag_in.neg = a[31] ^ b[31];
        case (func_in)
            FN_ADD:  tag_in.simple = a + b;
            FN_SUB:  tag_in.simple = a - b;
            FN_DIV:  tag_in.dz = (b == 0);
            FN_LT:   tag_in.flag = a < b;
            FN_GT:   tag_in.flag = a > b;
            FN_LE:   tag_in.flag = a <= b;
            FN_GE:   tag_in.flag = a >= b;
            FN_EQ:   tag_in.flag = a == b;
            FN_NE:   tag_in.flag = a != b;
            FN_INC:  tag_in.simple = a + 32'sd1;
            FN_DEC:  tag_in.simple = a - 32'sd1;
            FN_MIN:  tag_in.simple = (a > b) ? b : a;
            FN_MAX:  tag_in.simple = (a > b) ? a : b;
            FN_FINT: tag_in.simple = a << FRAC_W;
            FN_TINT: tag_in.simple = a >>> FRAC_W;
            default: tag_in.simple = '0;
        endcase
    end

    // stage 0 registers operands for both arithmetic units
    logic signed [31:0] a_reg, b_reg;
    logic [31:0] amag_reg, bmag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_reg <= a;
            b_reg <= b;
            amag_reg <= amag;
            bmag_reg <= bmag;
            tag_reg[0] <= tag_in;
            for (int i = 1; i < DEPTH; i++) tag_reg[i] <= tag_reg[i-1];
        end
    end

    logic [31:0] prod, quo;

    fpa_mul #(.FRAC_W(FRAC_W), .LAT(DSTG)) u_mul (
        .aclk(aclk), .en(adv), .a(a_reg), .b(b_reg), .p(prod)
    );

    fpa_div #(.FRAC_W(FRAC_W), .STAGES(DSTG)) u_div (
        .aclk(aclk), .en(adv), .num_mag(amag_reg), .den_mag(bmag_reg), .q(quo)
    );

    tag_t t;
    logic [31:0] res;
    always_comb begin
        t = tag_reg[DEPTH-1];
        case (t.func)
            FN_MUL:  res = prod;
            FN_DIV:  res = t.dz ? 32'd0 : (t.neg ? 32'(-quo) : quo);
            default: res = t.simple;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (adv) begin
            out_v_reg <= vld_reg[DEPTH-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_d_reg <= res;
            out_u_reg <= {t.dz, t.flag};
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;
    assign m_tuser  = out_u_reg;
endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the pipelined fixed-point alu
module testbench;
    import fpa_pkg::*;

    localparam int FRAC = 8;

    typedef struct {
        func_t       fn;
        logic [31:0] opa;
        logic [31:0] opb;
    } alu_op_t;

    typedef struct {
        logic [31:0] value;
        logic        flag;
        logic        dz;
    } alu_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic        s_tready_q = 1'b0;
    logic [63:0] s_tdata = '0;
    logic [3:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    alu_op_t  op_queue[$];
    alu_res_t expected_results[$];
    int       errors = 0;
    int       n_checked = 0;
    int       src_idle = 0;
    int       sink_idle = 0;
    int       sink_hold = 0;
    bit       calm = 1'b0;
    bit       src_pause = 1'b0;
    bit       stim_done = 1'b0;
    bit       cur_valid = 1'b0;
    alu_op_t  cur_op;

    fixed_point_alu #(.FRAC_W(FRAC)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial forever #2 aclk = ~aclk;

    function automatic alu_res_t alu_compute(alu_op_t op);
        alu_res_t    r;
        logic signed [31:0] a, b;
        logic signed [63:0] prod, num, q;
        a = op.opa;
        b = op.opb;
        r = '{32'd0, 1'b0, 1'b0};
        case (op.fn)
            FN_ADD:  r.value = op.opa + op.opb;
            FN_SUB:  r.value = op.opa - op.opb;
            FN_MUL: begin
                prod = 64'(a) * 64'(b);
                prod = prod >>> FRAC;
                r.value = prod[31:0];
            end
            FN_DIV: begin
                if (b == 0) r.dz = 1'b1;
                else begin
                    num = 64'(a) <<< FRAC;
                    q = num / 64'(b);   // signed division truncates toward zero
                    r.value = q[31:0];
                end
            end
            FN_LT:   r.flag = a < b;
            FN_GT:   r.flag = a > b;
            FN_LE:   r.flag = a <= b;
            FN_GE:   r.flag = a >= b;
            FN_EQ:   r.flag = a == b;
            FN_NE:   r.flag = a != b;
            FN_INC:  r.value = op.opa + 32'd1;
            FN_DEC:  r.value = op.opa - 32'd1;
            FN_MIN:  r.value = (a > b) ? op.opb : op.opa;
            FN_MAX:  r.value = (a > b) ? op.opa : op.opb;
            FN_FINT: r.value = op.opa << FRAC;
            default: r.value = a >>> FRAC;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(int'($urandom_range(0, 16)) - 8);
            3: return 32'(int'($urandom_range(0, 4096)) - 2048);
            4: return {{16{1'b0}}, 16'($urandom)};
            5: return {{16{1'b1}}, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic push_op(func_t fn, logic [31:0] a, logic [31:0] b);
        op_queue.push_back('{fn, a, b});
    endtask

    // driver: items offered at the falling edge
    always @(negedge aclk) begin
        bit offered;
        if (aresetn) begin
            if (cur_valid && s_tvalid && s_tready_q) cur_valid = 1'b0;
            // an item already offered stays on the bus until its transfer
            offered = cur_valid && s_tvalid;
            if (!cur_valid && op_queue.size() > 0) begin
                cur_op = op_queue.pop_front();
                cur_valid = 1'b1;
            end
            if (src_idle > 0) src_idle--;
            else if (!calm && $urandom_range(0, 19) == 0) src_idle = $urandom_range(1, 17);
            s_tvalid <= cur_valid && (offered || (src_idle == 0 && !src_pause));
            s_tdata <= {cur_op.opb, cur_op.opa};
            s_tuser <= cur_op.fn;
            if (sink_hold > 0) sink_hold--;
            if (sink_idle > 0) sink_idle--;
            else if (!calm && $urandom_range(0, 19) == 0) sink_idle = $urandom_range(1, 17);
            m_tready <= sink_hold == 0 && sink_idle == 0;
        end
    end

    // accepted input transfers recorded at the rising edge
    always @(posedge aclk) begin
        s_tready_q <= s_tready;
        if (aresetn && s_tvalid && s_tready)
            expected_results.push_back(alu_compute(cur_op));
    end

    // monitor
    always @(posedge aclk) begin
        alu_res_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h/%b", $time, m_tdata, m_tuser);
                errors++;
            end else begin
                e = expected_results.pop_front();
                n_checked++;
                if (m_tdata !== e.value || m_tuser[0] !== e.flag || m_tuser[1] !== e.dz) begin
                    $display("%0t: mismatch expected %h flag %b dz %b, got %h flag %b dz %b",
                             $time, e.value, e.flag, e.dz, m_tdata, m_tuser[0], m_tuser[1]);
                    errors++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int k;
        func_t fn;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        // directed: every operation at the extremes and the division corners
        for (int f = 0; f < 16; f++)
            push_op(func_t'(f), 32'h8000_0000, 32'h7fff_ffff);
        push_op(FN_DIV, 32'h0000_1234, 32'd0);
        push_op(FN_DIV, 32'h8000_0000, 32'hffff_ffff);
        push_op(FN_DIV, 32'hffff_fd00, 32'h0000_0200);
        push_op(FN_MUL, 32'h8000_0000, 32'h8000_0000);
        push_op(FN_TINT, 32'hffff_ff01, 32'd0);
        push_op(FN_INC, 32'h7fff_ffff, 32'hffff_ffff);
        push_op(FN_DEC, 32'h8000_0000, 32'd0);
        push_op(FN_EQ, 32'hffff_ffff, 32'hffff_ffff);
        push_op(FN_MIN, 32'd5, 32'd5);
        for (k = 0; k < 1500; k++) begin
            fn = func_t'($urandom_range(0, 15));
            push_op(fn, pick_operand(), ($urandom_range(0, 15) == 0) ? 32'd0 : pick_operand());
            if (k == 500) begin
                // long hold on the result side while items keep coming
                wait (op_queue.size() < 400);
                @(negedge aclk) sink_hold = 200;
                wait (sink_hold == 0);
            end
            if (k == 900) begin
                wait (op_queue.size() == 0 && !cur_valid);
                src_pause = 1'b1;
                wait (expected_results.size() == 0);
                src_pause = 1'b0;
            end
            if (k == 1300) calm = 1'b1;
        end
        wait (op_queue.size() == 0 && !cur_valid);
        wait (expected_results.size() == 0);
        repeat (20) @(posedge aclk);
        $display("checked %0d results over all sixteen operations with random stalls", n_checked);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
